// File: rtl/ftpdpp_pkg.sv
// Shared types, character codes and the per-format scan programs of the
// FTP data-port parser. No dependencies; all rtl/ modules use it.
package ftpdpp_pkg;

  typedef enum logic [1:0] {
    FMT_PORT = 2'd0,
    FMT_PASV = 2'd1,
    FMT_EPSV = 2'd2,
    FMT_EPRT = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    TK_LIT = 2'd0,
    TK_WS  = 2'd1,
    TK_NUM = 2'd2,
    TK_CHR = 2'd3
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] ch;
  } tok_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic [1:0] func;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic        port_valid;
    logic [15:0] data_port;
  } res_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  localparam logic [15:0] PORT_MAX = 16'hFFFF;
  localparam logic [7:0]  BYTE_MAX = 8'hFF;

  localparam tok_t T_WS  = '{kind: TK_WS,  ch: CH_NUL};
  localparam tok_t T_NUM = '{kind: TK_NUM, ch: CH_NUL};
  localparam tok_t T_CHR = '{kind: TK_CHR, ch: CH_NUL};
  localparam tok_t T_PAD = '{kind: TK_LIT, ch: CH_NUL};
  localparam tok_t T_CMA = '{kind: TK_LIT, ch: CH_COMMA};
  localparam tok_t T_DOT = '{kind: TK_LIT, ch: CH_DOT};
  localparam tok_t T_BAR = '{kind: TK_LIT, ch: CH_BAR};
  localparam tok_t T_LP  = '{kind: TK_LIT, ch: CH_LPAR};
  localparam tok_t T_RP  = '{kind: TK_LIT, ch: CH_RPAR};
  localparam tok_t T_ONE = '{kind: TK_LIT, ch: CH_ONE};

  // PORT " h,h,h,h,p,p"
  localparam tok_t PROG_PORT [16] = '{
    T_WS, T_NUM, T_CMA, T_NUM, T_CMA, T_NUM, T_CMA, T_NUM,
    T_CMA, T_NUM, T_CMA, T_NUM, T_CHR, T_PAD, T_PAD, T_PAD
  };
  // PASV "(h,h,h,h,p,p)" followed by up to two trailing characters
  localparam tok_t PROG_PASV [16] = '{
    T_LP, T_NUM, T_CMA, T_NUM, T_CMA, T_NUM, T_CMA, T_NUM,
    T_CMA, T_NUM, T_CMA, T_NUM, T_RP, T_CHR, T_CHR, T_PAD
  };
  // EPSV "(|||port|)"
  localparam tok_t PROG_EPSV [16] = '{
    T_LP, T_BAR, T_BAR, T_BAR, T_NUM, T_BAR, T_RP, T_CHR,
    T_PAD, T_PAD, T_PAD, T_PAD, T_PAD, T_PAD, T_PAD, T_PAD
  };
  // EPRT " |1|a.b.c.d|port|"
  localparam tok_t PROG_EPRT [16] = '{
    T_WS, T_BAR, T_ONE, T_BAR, T_NUM, T_DOT, T_NUM, T_DOT,
    T_NUM, T_DOT, T_NUM, T_BAR, T_NUM, T_BAR, T_CHR, T_PAD
  };

  function automatic tok_t prog_tok(fmt_e f, logic [3:0] ph);
    tok_t t;
    case (f)
      FMT_PORT: t = PROG_PORT[ph];
      FMT_PASV: t = PROG_PASV[ph];
      FMT_EPSV: t = PROG_EPSV[ph];
      default:  t = PROG_EPRT[ph];
    endcase
    return t;
  endfunction

  function automatic logic [3:0] prog_len(fmt_e f);
    logic [3:0] n;
    case (f)
      FMT_PORT: n = 4'd13;
      FMT_PASV: n = 4'd15;
      FMT_EPSV: n = 4'd8;
      default:  n = 4'd15;
    endcase
    return n;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

// File: rtl/ftpdpp_in_if.sv
// Input channel of the FTP data-port parser: one line byte per word.
// Depends on nothing.
interface ftpdpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic [1:0] func;
  logic       line_end;

  modport source (output valid, output line_byte, output func, output line_end, input ready);
  modport sink   (input valid, input line_byte, input func, input line_end, output ready);
endinterface

// File: rtl/ftpdpp_out_if.sv
// Output channel of the FTP data-port parser: one parse result per word.
// Depends on nothing.
interface ftpdpp_out_if;
  logic        valid;
  logic        ready;
  logic        port_valid;
  logic [15:0] data_port;

  modport source (output valid, output port_valid, output data_port, input ready);
  modport sink   (input valid, input port_valid, input data_port, output ready);
endinterface

// File: rtl/ftpdpp_scan.sv
// Per-byte scan step of the FTP data-port parser and the parse state it keeps.
// Depends on ftpdpp_pkg.
module ftpdpp_scan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  ftpdpp_pkg::in_item_t  item_i,
  output ftpdpp_pkg::res_t      res_o
);

  typedef struct packed {
    logic [3:0]  phase;
    logic        stopped;
    logic [2:0]  nidx;
    logic [15:0] acc;
    logic        digit;
    logic        sign;
    logic        minus;
    logic        ovf;
    logic [7:0]  hi;
    logic [15:0] port;
    logic [1:0]  trail;
    logic        dot;
    logic        failed;
  } st_t;

  localparam st_t ST_RESTART = '0;
  localparam st_t ST_CLEAR   = '{failed: 1'b1, default: '0};

  // Close the number being converted: range check and port capture.
  function automatic st_t finish(st_t s_in, ftpdpp_pkg::fmt_e f);
    st_t  s;
    logic big;
    s   = s_in;
    big = (f == ftpdpp_pkg::FMT_EPSV && s.nidx == 3'd0) ||
          (f == ftpdpp_pkg::FMT_EPRT && s.nidx == 3'd4);
    if (s.ovf || (s.minus && s.acc != '0) || (!big && s.acc > 16'(ftpdpp_pkg::BYTE_MAX))) begin
      s.failed = 1'b1;
    end
    if (f == ftpdpp_pkg::FMT_PORT || f == ftpdpp_pkg::FMT_PASV) begin
      if (s.nidx == 3'd4) begin
        s.hi = s.acc[7:0];
      end else if (s.nidx == 3'd5) begin
        s.port = {s.hi, s.acc[7:0]};
      end
    end else if (big) begin
      s.port = s.acc;
    end
    s.nidx  = s.nidx + 3'd1;
    s.acc   = '0;
    s.digit = 1'b0;
    s.sign  = 1'b0;
    s.minus = 1'b0;
    s.ovf   = 1'b0;
    return s;
  endfunction

  // One byte against the format program. A byte visits at most two items:
  // a skipped whitespace item or a closed number hands it to the next one.
  function automatic st_t feed(st_t s_in, ftpdpp_pkg::fmt_e f, logic [7:0] c);
    st_t              s;
    logic             cont;
    logic             sp;
    logic             dig;
    logic [19:0]      n;
    ftpdpp_pkg::tok_t tk;
    s    = s_in;
    cont = 1'b1;
    sp   = ftpdpp_pkg::is_space(c);
    dig  = (c >= ftpdpp_pkg::CH_ZERO) && (c <= ftpdpp_pkg::CH_NINE);
    for (int k = 0; k < 2; k++) begin
      tk = ftpdpp_pkg::prog_tok(f, s.phase);
      n  = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {16'd0, c[3:0]};
      if (cont) begin
        cont = 1'b0;
        if (s.phase >= ftpdpp_pkg::prog_len(f)) begin
          s.stopped = 1'b1;
        end else begin
          unique case (tk.kind)
            ftpdpp_pkg::TK_WS: begin
              if (!sp) begin
                s.phase = s.phase + 4'd1;
                cont    = 1'b1;
              end
            end
            ftpdpp_pkg::TK_CHR: begin
              if (f == ftpdpp_pkg::FMT_PASV && s.trail == 2'd0) begin
                s.dot = (c == ftpdpp_pkg::CH_DOT);
              end
              s.trail = s.trail + 2'd1;
              s.phase = s.phase + 4'd1;
            end
            ftpdpp_pkg::TK_NUM: begin
              if (!s.digit && !s.sign && sp) begin
                s.sign = s.sign;
              end else if (!s.digit && !s.sign &&
                           (c == ftpdpp_pkg::CH_PLUS || c == ftpdpp_pkg::CH_MINUS)) begin
                s.sign  = 1'b1;
                s.minus = (c == ftpdpp_pkg::CH_MINUS);
              end else if (dig) begin
                s.digit = 1'b1;
                if (!s.ovf) begin
                  if (n > {4'd0, ftpdpp_pkg::PORT_MAX}) begin
                    s.ovf = 1'b1;
                  end else begin
                    s.acc = n[15:0];
                  end
                end
              end else if (!s.digit) begin
                s.stopped = 1'b1;
              end else begin
                s       = finish(s, f);
                s.phase = s.phase + 4'd1;
                cont    = 1'b1;
              end
            end
            default: begin
              if (c == tk.ch) begin
                s.phase = s.phase + 4'd1;
              end else begin
                s.stopped = 1'b1;
              end
            end
          endcase
        end
      end
    end
    return s;
  endfunction

  st_t              st_q, st_d, st_e;
  ftpdpp_pkg::fmt_e fmt_q, fmt_d;
  logic             past_q, past_d;
  logic             term_q, term_d;
  logic             valid;

  always_comb begin
    st_d   = st_q;
    fmt_d  = fmt_q;
    past_d = past_q;
    term_d = term_q;
    if (!past_q) begin
      fmt_d  = ftpdpp_pkg::fmt_e'(item_i.func);
      past_d = 1'b1;
      if (item_i.line_byte == ftpdpp_pkg::CH_NUL) begin
        term_d = 1'b1;
      end
    end else if (!term_q) begin
      if (item_i.line_byte == ftpdpp_pkg::CH_NUL) begin
        term_d = 1'b1;
      end else begin
        if (item_i.line_byte == ftpdpp_pkg::CH_SPACE ||
            item_i.line_byte == ftpdpp_pkg::CH_LPAR) begin
          st_d = ST_RESTART;
        end
        if (!st_d.failed && !st_d.stopped) begin
          st_d = feed(st_d, fmt_q, item_i.line_byte);
        end
      end
    end

    // A number still open at the end of the line is closed here.
    st_e = st_d;
    if (!st_e.failed && !st_e.stopped && st_e.phase < ftpdpp_pkg::prog_len(fmt_d) &&
        ftpdpp_pkg::prog_tok(fmt_d, st_e.phase).kind == ftpdpp_pkg::TK_NUM && st_e.digit) begin
      st_e = finish(st_e, fmt_d);
    end

    valid = 1'b0;
    if (!st_e.failed) begin
      case (fmt_d)
        ftpdpp_pkg::FMT_PORT: valid = st_e.nidx == 3'd6 && st_e.trail == 2'd0;
        ftpdpp_pkg::FMT_PASV: valid = st_e.nidx == 3'd6 &&
                                      (st_e.trail == 2'd0 || (st_e.trail == 2'd1 && st_e.dot));
        ftpdpp_pkg::FMT_EPSV: valid = st_e.nidx == 3'd1 && st_e.trail == 2'd0;
        default:              valid = st_e.nidx == 3'd5 && st_e.trail == 2'd0;
      endcase
    end
    res_o.port_valid = valid;
    res_o.data_port  = valid ? st_e.port : '0;

    if (item_i.line_end) begin
      st_d   = ST_CLEAR;
      fmt_d  = ftpdpp_pkg::FMT_PORT;
      past_d = 1'b0;
      term_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_CLEAR;
      fmt_q  <= ftpdpp_pkg::FMT_PORT;
      past_q <= 1'b0;
      term_q <= 1'b0;
    end else if (step_i) begin
      st_q   <= st_d;
      fmt_q  <= fmt_d;
      past_q <= past_d;
      term_q <= term_d;
    end
  end

endmodule

// File: rtl/ftpdpp_out_reg.sv
// Result register of the FTP data-port parser, driving the output channel.
// Depends on ftpdpp_pkg and ftpdpp_out_if.
module ftpdpp_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  ftpdpp_pkg::res_t   res_i,
  output logic               free_o,
  ftpdpp_out_if.source       out_o
);

  logic             valid_q, valid_d;
  ftpdpp_pkg::res_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.port_valid = res_q.port_valid;
  assign out_o.data_port  = res_q.data_port;

endmodule

// File: rtl/ftp_data_port_parser.sv
// Top level of the FTP data-port parser: input register, scan step, result register.
// Depends on ftpdpp_pkg, ftpdpp_in_if, ftpdpp_out_if, ftpdpp_scan and ftpdpp_out_reg.
//
// The parser takes one byte of an FTP PORT, PASV, EPSV or EPRT line per word and
// sustains one byte per clock cycle while no line_end byte is held back. Each accepted
// byte is first captured in an input register; from there the scan step advances the
// parse state in one pass and, when the byte carries line_end, writes the result into
// the output register, from which it is offered on the output channel. That one-pass
// scan step, bounded by the decimal accumulate and range compare, sets the rate.
// Bytes that do not end a line keep flowing even while a finished result waits to be
// taken; only a line_end byte waits for the result register to free up. The format
// is taken from func on the first byte of each line, and the parser returns to its
// idle line state after every line_end. There is no initialization sequence after
// reset.
module ftp_data_port_parser (
  input  logic   clk_i,
  input  logic   rst_ni,
  ftpdpp_in_if.sink    in_i,
  ftpdpp_out_if.source out_o
);

  // Input register stage.
  logic                 s1_valid_q, s1_valid_d;
  ftpdpp_pkg::in_item_t s1_item_q;
  logic                 in_fire;

  // Scan and result handoff.
  logic             out_free;
  logic             fire;
  logic             res_load;
  ftpdpp_pkg::res_t scan_res;

  // The held byte proceeds unless it ends a line and the result slot is busy.
  assign fire     = s1_valid_q && (!s1_item_q.line_end || out_free);
  assign res_load = fire && s1_item_q.line_end;

  assign in_i.ready = !s1_valid_q || fire;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_i.ready) begin
      s1_valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= '{line_byte: in_i.line_byte, func: in_i.func, line_end: in_i.line_end};
    end
  end

  ftpdpp_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .item_i (s1_item_q),
    .res_o  (scan_res)
  );

  ftpdpp_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_load),
    .res_i  (scan_res),
    .free_o (out_free),
    .out_o  (out_o)
  );

  // A byte held in the input register but not stepped must stay there unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !fire |=> s1_valid_q && $stable(s1_item_q))
    else $error("held input byte was lost or overwritten");

  // A new result only appears after a line_end byte was stepped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(res_load))
    else $error("result appeared without a line end");

  // A rejected argument never reports a port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.port_valid |-> out_o.data_port == 16'd0)
    else $error("invalid result carries a nonzero port");

endmodule

// File: tb/sv/tb_ftp_data_port_parser.sv
// Self-checking testbench for the FTP data-port parser: drives PORT, PASV, EPSV
// and EPRT lines one byte per word and checks every parse result.
// Depends on ftpdpp_pkg, ftpdpp_in_if, ftpdpp_out_if and ftp_data_port_parser.
module tb_ftp_data_port_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import ftpdpp_pkg::*;

  // Number of random bytes that follow the directed lines, and the length of
  // each long output stall that backs the parser up into its input.
  localparam int RANDOM_BYTES = 1550;
  localparam int LONG_HOLD    = 400;

  typedef bit [7:0] octets_t [$];

  // One directed line. Where typed is set, the expected result is written in
  // the row itself; otherwise the line is checked against the byte-level
  // parser model below. nul_at replaces one byte with NUL (-1 for none), and
  // scramble drives a random format code on every byte after the first.
  typedef struct {
    string  text;
    fmt_e   fmt;
    int     nul_at;
    bit     scramble;
    bit     typed;
    res_t   want;
  } probe_t;

  localparam res_t NO_PORT = '{port_valid: 1'b0, data_port: 16'd0};

  // Argument grammar of each format, as a list of scan items: whitespace
  // skip, unsigned number, exact literal or any single trailing character.
  localparam tok_t K_WS    = '{kind: TK_WS,  ch: CH_NUL};
  localparam tok_t K_NUM   = '{kind: TK_NUM, ch: CH_NUL};
  localparam tok_t K_CHR   = '{kind: TK_CHR, ch: CH_NUL};
  localparam tok_t K_PAD   = '{kind: TK_LIT, ch: CH_NUL};
  localparam tok_t K_COMMA = '{kind: TK_LIT, ch: CH_COMMA};
  localparam tok_t K_DOT   = '{kind: TK_LIT, ch: CH_DOT};
  localparam tok_t K_BAR   = '{kind: TK_LIT, ch: CH_BAR};
  localparam tok_t K_OPEN  = '{kind: TK_LIT, ch: CH_LPAR};
  localparam tok_t K_CLOSE = '{kind: TK_LIT, ch: CH_RPAR};
  localparam tok_t K_ONE   = '{kind: TK_LIT, ch: CH_ONE};

  localparam tok_t ARG_GRAMMAR [4][16] = '{
    '{K_WS, K_NUM, K_COMMA, K_NUM, K_COMMA, K_NUM, K_COMMA, K_NUM,
      K_COMMA, K_NUM, K_COMMA, K_NUM, K_CHR, K_PAD, K_PAD, K_PAD},
    '{K_OPEN, K_NUM, K_COMMA, K_NUM, K_COMMA, K_NUM, K_COMMA, K_NUM,
      K_COMMA, K_NUM, K_COMMA, K_NUM, K_CLOSE, K_CHR, K_CHR, K_PAD},
    '{K_OPEN, K_BAR, K_BAR, K_BAR, K_NUM, K_BAR, K_CLOSE, K_CHR,
      K_PAD, K_PAD, K_PAD, K_PAD, K_PAD, K_PAD, K_PAD, K_PAD},
    '{K_WS, K_BAR, K_ONE, K_BAR, K_NUM, K_DOT, K_NUM, K_DOT,
      K_NUM, K_DOT, K_NUM, K_BAR, K_NUM, K_BAR, K_CHR, K_PAD}
  };
  localparam int ARG_LEN [4] = '{13, 15, 8, 15};

  logic clk_i;
  logic rst_ni;

  ftpdpp_in_if  byte_if ();
  ftpdpp_out_if res_if ();

  ftp_data_port_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (res_if)
  );

  // Parser model state. A line is ignored until its first space or '(' after
  // the first byte; every such delimiter restarts the argument scan.
  fmt_e        cur_fmt;
  bit          begun;
  bit          text_ended;
  bit          rejected;
  bit          halted;
  int          phase;
  bit [2:0]    nums_done;
  int unsigned acc;
  bit          have_digit;
  bit          have_sign;
  bit          negative;
  bit          overflowed;
  bit [7:0]    port_hi;
  bit [15:0]   port_acc;
  bit [1:0]    tail_cnt;
  bit          tail_dot;

  res_t pending_ports [$];
  int   lines_sent;
  int   bytes_sent;
  int   results_seen;
  int   valid_ports;
  int   errors;

  // Directed lines: field extremes, every format, signs, overflow, early
  // stop, NUL-terminated text, a changing format code and missing delimiters.
  probe_t probes [24] = '{
    '{"PORT 0,0,0,0,0,0", FMT_PORT, -1, 1'b0, 1'b1, '{1'b1, 16'd0}},
    '{"PORT 255,255,255,255,255,255", FMT_PORT, -1, 1'b0, 1'b1, '{1'b1, 16'hFFFF}},
    '{"PORT 1,2,3,4,256,1", FMT_PORT, -1, 1'b0, 1'b1, NO_PORT},
    '{"PORT 1,2,3,-1,5,6", FMT_PORT, -1, 1'b0, 1'b1, NO_PORT},
    '{"PORT +1,-0,-00,\t2,3,4", FMT_PORT, -1, 1'b0, 1'b0, NO_PORT},
    '{"PORT 1,2,3,4,5,6x", FMT_PORT, -1, 1'b0, 1'b1, NO_PORT},
    '{"PORT 1,2,3,4,5,6?", FMT_PORT, 16, 1'b0, 1'b0, NO_PORT},
    '{"xPORT 1,2,3,4,5,6", FMT_PORT, 0, 1'b0, 1'b1, NO_PORT},
    '{"PORT 1,2,3,4,5,6", FMT_PORT, -1, 1'b1, 1'b0, NO_PORT},
    '{"PORTX", FMT_PORT, -1, 1'b0, 1'b1, NO_PORT},
    '{"P", FMT_EPRT, -1, 1'b0, 1'b1, NO_PORT},
    '{"\377\200 1,2,3,4,5,6", FMT_PORT, -1, 1'b0, 1'b0, NO_PORT},
    '{"227 (10,0,0,1,4,1).", FMT_PASV, -1, 1'b0, 1'b1, '{1'b1, 16'd1025}},
    '{"227 (10,0,0,1,4,1).x", FMT_PASV, -1, 1'b0, 1'b1, NO_PORT},
    '{"227 (1,2 (7,8,9,10,11,12)", FMT_PASV, -1, 1'b0, 1'b0, NO_PORT},
    '{"227 (1,2,3,4,5,6]x", FMT_PASV, -1, 1'b0, 1'b0, NO_PORT},
    '{"x(", FMT_PASV, -1, 1'b0, 1'b1, NO_PORT},
    '{"229 (|||65535|)", FMT_EPSV, -1, 1'b0, 1'b1, '{1'b1, 16'hFFFF}},
    '{"229 (|||65536|)", FMT_EPSV, -1, 1'b0, 1'b1, NO_PORT},
    '{"229 (|||99999999|)", FMT_EPSV, -1, 1'b0, 1'b1, NO_PORT},
    '{"229 (|||21]", FMT_EPSV, -1, 1'b0, 1'b0, NO_PORT},
    '{"EPRT |1|0.0.0.0|0|", FMT_EPRT, -1, 1'b0, 1'b1, '{1'b1, 16'd0}},
    '{"EPRT |1|255.255.255.255|65535|", FMT_EPRT, -1, 1'b0, 1'b1, '{1'b1, 16'hFFFF}},
    '{"EPRT |1|1.2.3.4|21|\r", FMT_EPRT, -1, 1'b0, 1'b1, NO_PORT}
  };

  // ---------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------

  function automatic bit is_blank(bit [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void clear_number();
    acc        = 0;
    have_digit = 1'b0;
    have_sign  = 1'b0;
    negative   = 1'b0;
    overflowed = 1'b0;
  endfunction

  function automatic void restart_arg();
    phase     = 0;
    halted    = 1'b0;
    nums_done = '0;
    clear_number();
    port_hi   = '0;
    port_acc  = '0;
    tail_cnt  = '0;
    tail_dot  = 1'b0;
    rejected  = 1'b0;
  endfunction

  function automatic void reset_line();
    restart_arg();
    cur_fmt    = FMT_PORT;
    begun      = 1'b0;
    text_ended = 1'b0;
    rejected   = 1'b1;
  endfunction

  // Ends the number being scanned: range check, then the port bytes. The
  // EPSV port and the EPRT port are 16-bit; everything else is one byte.
  function automatic void close_number();
    int unsigned ceiling;
    ceiling = BYTE_MAX;
    if ((cur_fmt == FMT_EPSV && nums_done == 3'd0) ||
        (cur_fmt == FMT_EPRT && nums_done == 3'd4))
      ceiling = PORT_MAX;
    if (overflowed || (negative && acc != 0) || acc > ceiling)
      rejected = 1'b1;
    if (cur_fmt == FMT_PORT || cur_fmt == FMT_PASV) begin
      if (nums_done == 3'd4)
        port_hi = acc[7:0];
      else if (nums_done == 3'd5)
        port_acc = {port_hi, acc[7:0]};
    end else if (ceiling == PORT_MAX) begin
      port_acc = acc[15:0];
    end
    nums_done = nums_done + 3'd1;
    clear_number();
  endfunction

  // Feeds one character to the argument scan. A whitespace skip that meets
  // a non-blank, or a number that meets a non-digit after its digits, moves
  // on and offers the same character to the next scan item.
  function automatic void scan_char(bit [7:0] c);
    tok_t        t;
    int unsigned grown;
    while (1'b1) begin
      if (phase >= ARG_LEN[cur_fmt]) begin
        halted = 1'b1;
        return;
      end
      t = ARG_GRAMMAR[cur_fmt][phase];
      case (t.kind)
        TK_WS: begin
          if (is_blank(c))
            return;
          phase++;
        end
        TK_CHR: begin
          if (cur_fmt == FMT_PASV && tail_cnt == 2'd0)
            tail_dot = (c == CH_DOT);
          tail_cnt++;
          phase++;
          return;
        end
        TK_NUM: begin
          if (!have_digit && !have_sign && is_blank(c))
            return;
          if (!have_digit && !have_sign && (c == CH_PLUS || c == CH_MINUS)) begin
            have_sign = 1'b1;
            negative  = (c == CH_MINUS);
            return;
          end
          if (c >= CH_ZERO && c <= CH_NINE) begin
            have_digit = 1'b1;
            if (!overflowed) begin
              grown = acc * 10 + 32'(c - CH_ZERO);
              if (grown > PORT_MAX)
                overflowed = 1'b1;
              else
                acc = grown;
            end
            return;
          end
          if (!have_digit) begin
            halted = 1'b1;
            return;
          end
          close_number();
          phase++;
        end
        default: begin
          if (c == t.ch)
            phase++;
          else
            halted = 1'b1;
          return;
        end
      endcase
    end
  endfunction

  // Advances the model by one accepted byte; on line_end it hands back the
  // parse result and returns to the idle line state.
  function automatic void parse_byte(in_item_t it, output bit produced, output res_t res);
    bit ok;
    produced = 1'b0;
    res      = NO_PORT;
    ok       = 1'b0;
    if (!begun) begin
      cur_fmt = fmt_e'(it.func);
      begun   = 1'b1;
      if (it.line_byte == CH_NUL)
        text_ended = 1'b1;
    end else if (!text_ended) begin
      if (it.line_byte == CH_NUL) begin
        text_ended = 1'b1;
      end else begin
        if (it.line_byte == CH_SPACE || it.line_byte == CH_LPAR)
          restart_arg();
        if (!rejected && !halted)
          scan_char(it.line_byte);
      end
    end
    if (!it.line_end)
      return;
    // A number still open at the end of the line counts as finished.
    if (!rejected && !halted && phase < ARG_LEN[cur_fmt] &&
        ARG_GRAMMAR[cur_fmt][phase].kind == TK_NUM && have_digit)
      close_number();
    if (!rejected) begin
      case (cur_fmt)
        FMT_PORT: ok = nums_done == 3'd6 && tail_cnt == 2'd0;
        FMT_PASV: ok = nums_done == 3'd6 &&
                       (tail_cnt == 2'd0 || (tail_cnt == 2'd1 && tail_dot));
        FMT_EPSV: ok = nums_done == 3'd1 && tail_cnt == 2'd0;
        default:  ok = nums_done == 3'd5 && tail_cnt == 2'd0;
      endcase
    end
    produced       = 1'b1;
    res.port_valid = ok;
    res.data_port  = ok ? port_acc : 16'd0;
    reset_line();
  endfunction

  // ---------------------------------------------------------------------
  // Line generation
  // ---------------------------------------------------------------------

  // Mostly zero, then short gaps, and now and then a long one.
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic octets_t to_octets(string s);
    octets_t q;
    for (int i = 0; i < s.len(); i++)
      q.push_back(s[i]);
    return q;
  endfunction

  function automatic string odd_char(int unsigned lo, int unsigned hi);
    string s;
    s    = "?";
    s[0] = 8'($urandom_range(lo, hi));
    return s;
  endfunction

  // A decimal field: mostly in range, sometimes past the limit or far past
  // it, with the occasional leading zeros, sign, minus zero or blank.
  function automatic string num_text(bit wide);
    int unsigned v;
    int unsigned r;
    string       s;
    r = $urandom_range(0, 99);
    if (wide)
      v = r < 55 ? $urandom_range(0, 65535) : r < 65 ? 65535 :
          r < 72 ? $urandom_range(65536, 999999) : $urandom_range(0, 1023);
    else
      v = r < 80 ? $urandom_range(0, 255) : r < 86 ? 255 :
          r < 93 ? $urandom_range(256, 70000) : $urandom_range(0, 9);
    s = $sformatf("%0d", v);
    r = $urandom_range(0, 99);
    if (r < 5)
      s = {"00", s};
    else if (r < 10)
      s = {"+", s};
    else if (r < 12)
      s = "-0";
    else if (r < 14)
      s = "-000";
    else if (r < 16)
      s = {"-", s};
    else if (r < 18)
      s = {s, "9999999"};
    if ($urandom_range(0, 99) < 8)
      s = {odd_char(CH_TAB, CH_CR), s};
    return s;
  endfunction

  // A line of the given format with random numbers and, sometimes, extra
  // bytes after the argument.
  function automatic string wellformed(fmt_e f);
    string s;
    case (f)
      FMT_PORT: begin
        s = ($urandom_range(0, 9) == 0) ? "PORT \t" : "PORT ";
        for (int k = 0; k < 6; k++) begin
          if (k != 0)
            s = {s, ","};
          s = {s, num_text(1'b0)};
        end
      end
      FMT_PASV: begin
        s = "227 (";
        for (int k = 0; k < 6; k++) begin
          if (k != 0)
            s = {s, ","};
          s = {s, num_text(1'b0)};
        end
        if ($urandom_range(0, 9) != 0)
          s = {s, ")"};
        if ($urandom_range(0, 99) < 40)
          s = {s, "."};
      end
      FMT_EPSV: begin
        s = {"229 (|||", num_text(1'b1), "|)"};
      end
      default: begin
        s = ($urandom_range(0, 19) == 0) ? "EPRT |2|" : "EPRT |1|";
        for (int k = 0; k < 4; k++) begin
          if (k != 0)
            s = {s, "."};
          s = {s, num_text(1'b0)};
        end
        s = {s, "|", num_text(1'b1), "|"};
      end
    endcase
    if ($urandom_range(0, 99) < 10)
      s = {s, odd_char(1, 255)};
    return s;
  endfunction

  // Most lines are well formed; the rest are byte noise or damaged lines.
  function automatic octets_t random_line(fmt_e f);
    octets_t     q;
    string       charset;
    int unsigned r;
    int unsigned n;
    int unsigned pos;
    charset = "0123456789,.|() +-\t";
    r = $urandom_range(0, 99);
    if (r < 10) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        if ($urandom_range(0, 1) != 0)
          q.push_back(8'($urandom_range(0, 255)));
        else
          q.push_back(charset[$urandom_range(0, charset.len() - 1)]);
      end
      return q;
    end
    q = to_octets(wellformed(f));
    if (r >= 72) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        pos = $urandom_range(0, q.size() - 1);
        case ($urandom_range(0, 4))
          0: q[pos] = 8'($urandom_range(0, 255));
          1: q.insert(pos, CH_NUL);
          2: if (q.size() > 1) q.delete(pos);
          3: q.insert(pos, ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_LPAR);
          default: while (q.size() > pos + 1) void'(q.pop_back());
        endcase
      end
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, reset and timeout
  // ---------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Even the slowest correct run stays far below this bound.
  initial begin
    #20ms;
    $error("timeout with %0d results still pending", pending_ports.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Byte sender
  // ---------------------------------------------------------------------

  // Sends one line, one word per byte. A quarter of the lines go without any
  // gaps; in the rest valid drops for a random number of cycles before a
  // byte. The model is advanced only at the edge where the word is taken.
  task automatic send_line(octets_t text, fmt_e f, bit scramble, bit typed, res_t want);
    in_item_t it;
    res_t     got;
    bit       produced;
    bit       calm;
    int       gap;
    calm = ($urandom_range(0, 3) == 0);
    lines_sent++;
    foreach (text[i]) begin
      it.line_byte = text[i];
      it.func      = (i == 0 || !scramble) ? f : 2'($urandom_range(0, 3));
      it.line_end  = (i == text.size() - 1);
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      byte_if.valid     <= 1'b1;
      byte_if.line_byte <= it.line_byte;
      byte_if.func      <= it.func;
      byte_if.line_end  <= it.line_end;
      do @(posedge clk_i); while (!byte_if.ready);
      bytes_sent++;
      parse_byte(it, produced, got);
      if (produced)
        pending_ports.push_back(typed ? want : got);
    end
  endtask

  initial begin
    octets_t text;
    fmt_e    f;
    int      random_start;
    rst_ni            = 1'b0;
    byte_if.valid     <= 1'b0;
    byte_if.line_byte <= '0;
    byte_if.func      <= '0;
    byte_if.line_end  <= 1'b0;
    reset_line();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines first.
    foreach (probes[i]) begin
      text = to_octets(probes[i].text);
      if (probes[i].nul_at >= 0)
        text[probes[i].nul_at] = CH_NUL;
      send_line(text, probes[i].fmt, probes[i].scramble, probes[i].typed, probes[i].want);
    end

    // Random lines of every format; the format code sometimes changes
    // in the middle of a line, which the parser must ignore.
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      f    = fmt_e'($urandom_range(0, 3));
      text = random_line(f);
      send_line(text, f, $urandom_range(0, 99) < 15, 1'b0, NO_PORT);
    end
    byte_if.valid <= 1'b0;

    // Drain, then keep watching for anything stray to show up.
    while (pending_ports.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d lines (%0d bytes) across PORT, PASV, EPSV and EPRT formats.",
             lines_sent, bytes_sent);
    $display("Checked %0d results, %0d with a valid port, through two long output stalls.",
             results_seen, valid_ports);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result receiver
  // ---------------------------------------------------------------------

  // ready alternates between high runs of random length and random gaps. Twice
  // during the run it is held low for a long stretch while bytes keep coming,
  // so the result register fills and the next line_end byte is stalled.
  initial begin
    int run;
    int pause;
    int holds;
    holds = 0;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (holds < 2 && results_seen >= 15 + holds * 40) begin
        pause = LONG_HOLD;
        holds++;
      end else begin
        pause = idle_len();
      end
      if (pause > 0) begin
        res_if.ready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk_i);
    end
  end

  // Each accepted result is compared with the oldest pending expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (pending_ports.size() == 0) begin
        $error("result with nothing pending: port_valid=%0b data_port=%0d",
               res_if.port_valid, res_if.data_port);
        errors++;
      end else begin
        want = pending_ports.pop_front();
        if (res_if.port_valid !== want.port_valid) begin
          $error("port_valid: expected %0b, got %0b", want.port_valid, res_if.port_valid);
          errors++;
        end
        if (res_if.data_port !== want.data_port) begin
          $error("data_port: expected %0d, got %0d", want.data_port, res_if.data_port);
          errors++;
        end
        if (want.port_valid)
          valid_ports++;
      end
    end
  end

endmodule
